[design/hcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_pkg: shared definitions of the hash chain list table
// Field widths, stream data widths, the default table size and the command
// codes of the request channel.
// ----------------------------------------------------------------------------
package hcl_pkg;

   // width of the bucket and position fields on the ports
   localparam int FieldW = 12;

   // default number of buckets and window positions
   localparam int DefaultTableSize = 4096;

   // request tdata: bucket, position (24 bits, already whole bytes)
   localparam int ReqDataW = 2 * FieldW;

   // response tdata: head_position, head_valid, old_head, old_head_valid
   localparam int RspUsedW = 2 * (FieldW + 1);
   localparam int RspDataW = ((RspUsedW + 7) / 8) * 8;
   localparam int RspPadW  = RspDataW - RspUsedW;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

endpackage

[design/hcl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_ram: generic single-clock RAM
// One write port and one read port, read data registered (old data returned
// when reading the address written in the same cycle).
// ----------------------------------------------------------------------------
module hcl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hash_chain_list_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_chain_list_table: LZ hash chains kept as doubly linked lists
// Insert puts a window position at the head of its bucket's chain, delete
// unlinks a position from a bucket's chain; each item returns the new head.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one item per operation. tuser carries the
//   command (insert or delete), tdata the bucket and the position.
//   Response channel (rsp_*): one item per request, in request order, with
//   the bucket head after the operation and, for an insert, the head that
//   it displaced.
//   An item goes through these steps from acceptance to the next acceptance:
//   reduce the indexes and read the head and node memories, update the head
//   and own node as the command needs, then one read-modify-write of the node
//   memory for each neighbor link that changes (none, one or two), hand the
//   item to the response register and go back to idle, the only state that
//   takes a request. The single read and write port of the node memory makes
//   each link fix a separate step.
//   While the receiver stalls, hold the finished item in the sequencer until
//   the response register frees up; req_tready stays low meanwhile.
//   After reset the block clears both memories, one entry a cycle, and holds
//   req_tready low during that pass.
// ----------------------------------------------------------------------------
module hash_chain_list_table import hcl_pkg::*; #(
   parameter int TableSize = DefaultTableSize
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // bucket[11:0], position[23:12]
   input  logic [0:0]          req_tuser,  // command[0]
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata   // head_position[11:0], head_valid[12],
                                           // old_head[24:13], old_head_valid[25]
);

   // -------------------------------------------------------------------------
   // Sizes
   // -------------------------------------------------------------------------
   localparam int IdxW     = $clog2(TableSize);
   localparam int ModShift = FieldW + IdxW;
   // reciprocal for an exact floor(v / TableSize) over every FieldW-bit v
   localparam longint ModRecip =
      ((longint'(1) << ModShift) + longint'(TableSize) - 1) / longint'(TableSize);
   localparam int RecipW   = $clog2(ModRecip + 1);
   localparam int ProdW    = FieldW + RecipW;
   localparam int TblW     = $clog2(TableSize + 1);
   localparam int ProdTW   = FieldW + TblW;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);

   typedef struct packed {
      logic            valid;
      logic [IdxW-1:0] idx;
   } entry_type;

   // one node word: bucket record, prev link, next link
   typedef struct packed {
      entry_type bkt;
      entry_type prev;
      entry_type next;
   } node_type;

   localparam int EntW  = $bits(entry_type);
   localparam int WordW = $bits(node_type);

   typedef enum logic [6:0] {
      ST_INIT = 7'b0000001,  // clearing pass
      ST_IDLE = 7'b0000010,  // wait for a request
      ST_LOOK = 7'b0000100,  // reduce indexes, read head and node
      ST_HEAD = 7'b0001000,  // update head, write own node on insert, start link fix
      ST_LNKA = 7'b0010000,  // rewrite next link of the predecessor
      ST_LNKB = 7'b0100000,  // rewrite prev link of the successor
      ST_DONE = 7'b1000000   // hand item to the response register
   } state_type;

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [IdxW-1:0]        clr_ff, clr_in;
   cmd_type                cmd_ff, cmd_in;
   logic [FieldW-1:0]      raw_b_ff, raw_b_in, raw_p_ff, raw_p_in;
   logic [FieldW-1:0]      quo_b_ff, quo_b_in, quo_p_ff, quo_p_in;
   logic [IdxW-1:0]        b_ff, b_in, p_ff, p_in;
   entry_type              head_ff, head_in;
   entry_type              old_ff, old_in;
   entry_type              pv_ff, pv_in, nx_ff, nx_in;
   logic [IdxW-1:0]        tgt_ff, tgt_in;
   entry_type              lnk_val_ff, lnk_val_in;
   logic                   fwd_ff, fwd_in;
   node_type               fwd_word_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]    rsp_data_ff, rsp_data_in;

   // -------------------------------------------------------------------------
   // Memory ports
   // -------------------------------------------------------------------------
   logic                   h_we, h_re, n_we, n_re;
   logic [IdxW-1:0]        h_waddr, h_raddr, n_waddr, n_raddr;
   entry_type              h_wdata;
   node_type               n_wdata;
   logic [EntW-1:0]        h_rdata;
   logic [WordW-1:0]       n_rdata;

   hcl_ram #(
      .Width (EntW),
      .Depth (TableSize)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_en   (h_re),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   hcl_ram #(
      .Width (WordW),
      .Depth (TableSize)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_en   (n_re),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   // -------------------------------------------------------------------------
   // Index reduction: quotient by reciprocal on accept, remainder in ST_LOOK
   // -------------------------------------------------------------------------
   logic              accept;
   logic [ProdW-1:0]  prod_b, prod_p;
   logic [ProdW-1:0]  prod_b_sh, prod_p_sh;
   logic [ProdTW-1:0] qt_b, qt_p;
   logic [FieldW-1:0] rem_b, rem_p;
   logic [IdxW-1:0]   idx_b, idx_p;

   assign accept = req_tvalid && req_tready;

   assign prod_b    = ProdW'(req_tdata[FieldW-1:0]) * ProdW'(ModRecip);
   assign prod_p    = ProdW'(req_tdata[2*FieldW-1:FieldW]) * ProdW'(ModRecip);
   assign prod_b_sh = prod_b >> ModShift;
   assign prod_p_sh = prod_p >> ModShift;

   assign qt_b  = ProdTW'(quo_b_ff) * ProdTW'(TableSize);
   assign qt_p  = ProdTW'(quo_p_ff) * ProdTW'(TableSize);
   assign rem_b = raw_b_ff - qt_b[FieldW-1:0];
   assign rem_p = raw_p_ff - qt_p[FieldW-1:0];
   assign idx_b = IdxW'(rem_b);
   assign idx_p = IdxW'(rem_p);

   // -------------------------------------------------------------------------
   // Read data views
   // -------------------------------------------------------------------------
   entry_type h_ent;
   node_type  n_node;
   node_type  lnkb_src;
   logic      rsp_free;

   assign h_ent    = entry_type'(h_rdata);
   assign n_node   = node_type'(n_rdata);
   // take the word written in the cycle of the read when the addresses met
   assign lnkb_src = fwd_ff ? fwd_word_ff : n_node;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   function automatic logic [FieldW:0] pack_entry(input entry_type e);
      logic [FieldW-1:0] pos;
      pos = e.valid ? FieldW'(e.idx) : '0;
      return {e.valid, pos};
   endfunction

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      raw_b_in     = raw_b_ff;
      raw_p_in     = raw_p_ff;
      quo_b_in     = quo_b_ff;
      quo_p_in     = quo_p_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      head_in      = head_ff;
      old_in       = old_ff;
      pv_in        = pv_ff;
      nx_in        = nx_ff;
      tgt_in       = tgt_ff;
      lnk_val_in   = lnk_val_ff;
      fwd_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      h_we    = 1'b0;
      h_waddr = b_ff;
      h_wdata = '0;
      h_re    = 1'b0;
      h_raddr = idx_b;
      n_we    = 1'b0;
      n_waddr = p_ff;
      n_wdata = '0;
      n_re    = 1'b0;
      n_raddr = idx_p;

      unique case (state_ff)
         ST_INIT: begin
            // sweep both memories to empty
            h_we    = 1'b1;
            h_waddr = clr_ff;
            n_we    = 1'b1;
            n_waddr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LastIdx) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               cmd_in   = cmd_type'(req_tuser[0]);
               raw_b_in = req_tdata[FieldW-1:0];
               raw_p_in = req_tdata[2*FieldW-1:FieldW];
               quo_b_in = prod_b_sh[FieldW-1:0];
               quo_p_in = prod_p_sh[FieldW-1:0];
               state_in = ST_LOOK;
            end
         end

         ST_LOOK: begin
            h_re     = 1'b1;
            h_raddr  = idx_b;
            n_re     = 1'b1;
            n_raddr  = idx_p;
            b_in     = idx_b;
            p_in     = idx_p;
            state_in = ST_HEAD;
         end

         ST_HEAD: begin
            unique case (cmd_ff)
               CMD_INSERT: begin
                  // new node becomes head, old head becomes its successor
                  h_we           = 1'b1;
                  h_waddr        = b_ff;
                  h_wdata        = '{valid: 1'b1, idx: p_ff};
                  n_we           = 1'b1;
                  n_waddr        = p_ff;
                  n_wdata.bkt    = '{valid: 1'b1, idx: b_ff};
                  n_wdata.prev   = '0;
                  n_wdata.next   = h_ent;
                  old_in         = h_ent;
                  head_in        = '{valid: 1'b1, idx: p_ff};
                  if (h_ent.valid) begin
                     n_re       = 1'b1;
                     n_raddr    = h_ent.idx;
                     tgt_in     = h_ent.idx;
                     lnk_val_in = '{valid: 1'b1, idx: p_ff};
                     fwd_in     = (h_ent.idx == p_ff);
                     state_in   = ST_LNKB;
                  end else begin
                     state_in   = ST_DONE;
                  end
               end

               CMD_DELETE: begin
                  old_in = '0;
                  if (h_ent.valid && (h_ent.idx == p_ff)) begin
                     // drop the head: successor moves up, loses its prev
                     h_we    = 1'b1;
                     h_waddr = b_ff;
                     h_wdata = n_node.next;
                     head_in = n_node.next;
                     if (n_node.next.valid) begin
                        n_re       = 1'b1;
                        n_raddr    = n_node.next.idx;
                        tgt_in     = n_node.next.idx;
                        lnk_val_in = '0;
                        state_in   = ST_LNKB;
                     end else begin
                        state_in   = ST_DONE;
                     end
                  end else begin
                     // unlink from the middle: bridge predecessor and successor
                     head_in = h_ent;
                     pv_in   = n_node.prev;
                     nx_in   = n_node.next;
                     priority if (n_node.prev.valid) begin
                        n_re     = 1'b1;
                        n_raddr  = n_node.prev.idx;
                        state_in = ST_LNKA;
                     end else if (n_node.next.valid) begin
                        n_re       = 1'b1;
                        n_raddr    = n_node.next.idx;
                        tgt_in     = n_node.next.idx;
                        lnk_val_in = n_node.prev;
                        state_in   = ST_LNKB;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               end

               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_LNKA: begin
            n_we         = 1'b1;
            n_waddr      = pv_ff.idx;
            n_wdata      = n_node;
            n_wdata.next = nx_ff;
            if (nx_ff.valid) begin
               n_re       = 1'b1;
               n_raddr    = nx_ff.idx;
               tgt_in     = nx_ff.idx;
               lnk_val_in = pv_ff;
               fwd_in     = (nx_ff.idx == pv_ff.idx);
               state_in   = ST_LNKB;
            end else begin
               state_in   = ST_DONE;
            end
         end

         ST_LNKB: begin
            n_we         = 1'b1;
            n_waddr      = tgt_ff;
            n_wdata      = lnkb_src;
            n_wdata.prev = lnk_val_ff;
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            // hold here while the previous response is still waiting
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RspPadW{1'b0}}, pack_entry(old_ff), pack_entry(head_ff)};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      raw_b_ff    <= raw_b_in;
      raw_p_ff    <= raw_p_in;
      quo_b_ff    <= quo_b_in;
      quo_p_ff    <= quo_p_in;
      b_ff        <= b_in;
      p_ff        <= p_in;
      head_ff     <= head_in;
      old_ff      <= old_in;
      pv_ff       <= pv_in;
      nx_ff       <= nx_in;
      tgt_ff      <= tgt_in;
      lnk_val_ff  <= lnk_val_in;
      fwd_word_ff <= n_wdata;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/hash_chain_list_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_chain_list_table_tb: self-checking bench of the hash chain list table
// Sends insert and delete items into the block and models the head, prev and
// next tables alongside it. Each response is checked against the modeled
// bucket head and displaced head. A directed opening covers the field
// extremes and the unusual link cases. Mostly well-formed random chains
// follow, with some noise mixed in, and both sides stall at random.
// ----------------------------------------------------------------------------
module hash_chain_list_table_tb;
   import hcl_pkg::*;

   localparam int TableSize   = DefaultTableSize;
   localparam int RandomOps   = 400;
   // The clearing pass after reset keeps req_tready low.
   localparam int IdleLimit   = 4 * TableSize + 2000;
   localparam int MaxReported = 10;

   // One table entry: a position plus a valid bit (empty when valid is 0).
   typedef struct packed {
      bit               valid;
      bit [FieldW-1:0]  pos;
   } link_type;

   // Response fields, listed from the top bit down so that the packed layout
   // matches rsp_tdata: head_position is in the lowest bits.
   typedef struct packed {
      logic              displaced_ok;
      logic [FieldW-1:0] displaced;
      logic              head_ok;
      logic [FieldW-1:0] head_pos;
   } head_report_type;

   // -------------------------------------------------------------------------
   // Chain tables plus the queue of bucket heads still owed by the block
   // -------------------------------------------------------------------------
   class chain_scoreboard;
      link_type        heads [TableSize];
      link_type        prevs [TableSize];
      link_type        nexts [TableSize];
      head_report_type expected_heads [$];
      int              mismatches;
      int              checked;

      function new();
         mismatches = 0;
         checked    = 0;
      endfunction

      function int pending();
         return expected_heads.size();
      endfunction

      // Apply one accepted operation to the tables and queue its report.
      // Node bucket records are never read back, so they are not kept.
      function void note_op(cmd_type cmd, logic [FieldW-1:0] bucket,
                            logic [FieldW-1:0] position);
         int              b;
         int              p;
         link_type        displaced;
         link_type        h;
         link_type        nh;
         link_type        pv;
         link_type        nx;
         head_report_type rep;
         b         = int'(bucket) % TableSize;
         p         = int'(position) % TableSize;
         displaced = '0;
         if (cmd == CMD_INSERT) begin
            displaced = heads[b];
            heads[b]  = '{valid: 1'b1, pos: p[FieldW-1:0]};
            prevs[p]  = '0;
            nexts[p]  = displaced;
            if (displaced.valid)
               prevs[displaced.pos] = '{valid: 1'b1, pos: p[FieldW-1:0]};
         end else begin
            h = heads[b];
            if (h.valid && h.pos == p[FieldW-1:0]) begin
               // unlink the head: its successor moves up and loses its prev
               nh       = nexts[p];
               heads[b] = nh;
               if (nh.valid)
                  prevs[nh.pos] = '0;
            end else begin
               // splice around the node, whether or not it is really here
               pv = prevs[p];
               nx = nexts[p];
               if (pv.valid)
                  nexts[pv.pos] = nx;
               if (nx.valid)
                  prevs[nx.pos] = pv;
            end
         end
         h                = heads[b];
         rep.head_ok      = h.valid;
         rep.head_pos     = h.valid ? h.pos : '0;
         rep.displaced_ok = displaced.valid;
         rep.displaced    = displaced.valid ? displaced.pos : '0;
         expected_heads.push_back(rep);
      endfunction

      // Compare one accepted response with the oldest queued report.
      function void check_head(logic [RspDataW-1:0] data);
         head_report_type got;
         head_report_type want;
         got = head_report_type'(data[RspUsedW-1:0]);
         checked++;
         if (expected_heads.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("response %0d arrived with nothing outstanding: head %0d/%0b",
                        checked, got.head_pos, got.head_ok);
            return;
         end
         want = expected_heads.pop_front();
         if (got.head_pos !== want.head_pos || got.head_ok !== want.head_ok ||
             got.displaced !== want.displaced ||
             got.displaced_ok !== want.displaced_ok) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display(
                  "response %0d: expected head %0d/%0b old %0d/%0b, got %0d/%0b old %0d/%0b",
                  checked, want.head_pos, want.head_ok, want.displaced,
                  want.displaced_ok, got.head_pos, got.head_ok, got.displaced,
                  got.displaced_ok);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;  // bucket[11:0], position[23:12]
   logic [0:0]          req_tuser  = '0;  // command[0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;        // head_position[11:0], head_valid[12],
                                          // old_head[24:13], old_head_valid[25]

   hash_chain_list_table #(.TableSize(TableSize)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   chain_scoreboard sb = new();

   // when set, the sender drops its gaps for a stretch of items
   bit send_burst = 1'b0;
   // when set, the receiver drops its stalls for a stretch of responses
   bit rsp_burst  = 1'b0;

   // bucket that each tracked position currently sits in, -1 when free
   int                chain_of [TableSize];
   logic [FieldW-1:0] live_q [$];
   // a few hot buckets so that chains grow long enough to have middles
   logic [FieldW-1:0] hot_buckets [6];

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Wait a random gap, present one item, hold it until accepted, and note
   // the accepted operation in the scoreboard. A zero gap keeps tvalid high
   // straight into the next item.
   task automatic send_op(cmd_type cmd, logic [FieldW-1:0] bucket,
                          logic [FieldW-1:0] position);
      int gap;
      gap = send_burst ? 0 : $urandom_range(8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {position, bucket};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_op(cmd, bucket, position);
   endtask

   // Hold the request side idle until every queued head has come back.
   task automatic drain_heads();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Insert a free position into a hot or random bucket, else fall back to
   // deleting; delete a tracked position from the bucket it really sits in.
   task automatic send_chain_op(bit want_insert);
      logic [FieldW-1:0] b;
      logic [FieldW-1:0] p;
      int                idx;
      int                tries;
      bit                found;
      found = 1'b0;
      if (want_insert || live_q.size() == 0) begin
         for (tries = 0; tries < 8 && !found; tries++) begin
            p = FieldW'($urandom_range(TableSize - 1));
            found = (chain_of[p] < 0);
         end
      end
      if (found) begin
         if ($urandom_range(9) < 7)
            b = hot_buckets[$urandom_range(5)];
         else
            b = FieldW'($urandom_range(TableSize - 1));
         chain_of[p] = int'(b);
         live_q.push_back(p);
         send_op(CMD_INSERT, b, p);
      end else begin
         idx = $urandom_range(live_q.size() - 1);
         p   = live_q[idx];
         b   = FieldW'(chain_of[p]);
         live_q.delete(idx);
         chain_of[p] = -1;
         send_op(CMD_DELETE, b, p);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int n;
      bit grow;
      foreach (chain_of[i]) chain_of[i] = -1;
      hot_buckets[0] = '0;
      hot_buckets[1] = '1;
      foreach (hot_buckets[i])
         if (i > 1) hot_buckets[i] = FieldW'($urandom_range(TableSize - 1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: field extremes, empty buckets, head, middle and
      // tail deletes, and the inconsistent cases the block must still define.
      send_op(CMD_INSERT, 12'd0, 12'd0);          // first node of an empty bucket
      send_op(CMD_INSERT, 12'hFFF, 12'hFFF);      // top bucket, top position
      send_op(CMD_INSERT, 12'd0, 12'hFFF);        // node already in another list
      send_op(CMD_INSERT, 12'd0, 12'd1);
      send_op(CMD_INSERT, 12'd0, 12'd2);          // chain 2, 1, 4095, 0
      send_op(CMD_DELETE, 12'd0, 12'd1);          // middle node
      send_op(CMD_DELETE, 12'd0, 12'd2);          // head node with a successor
      send_op(CMD_DELETE, 12'd0, 12'd0);          // tail node
      send_op(CMD_DELETE, 12'd0, 12'hFFF);        // last node, bucket empties
      send_op(CMD_DELETE, 12'd0, 12'd3);          // empty bucket, node not listed
      send_op(CMD_INSERT, 12'd7, 12'd4);
      send_op(CMD_INSERT, 12'd7, 12'd5);          // chain 5, 4
      send_op(CMD_DELETE, 12'd9, 12'd5);          // non-head with empty prev link
      send_op(CMD_DELETE, 12'd7, 12'd5);          // head whose successor is clean
      send_op(CMD_DELETE, 12'd7, 12'd4);
      send_op(CMD_INSERT, 12'hAAA, 12'h555);
      send_op(CMD_INSERT, 12'h555, 12'hAAA);
      send_op(CMD_INSERT, 12'h555, 12'hAAA);      // same node inserted twice
      send_op(CMD_DELETE, 12'h555, 12'hAAA);      // head that links to itself
      send_op(CMD_DELETE, 12'hFFF, 12'hFFF);      // head left stale by a reinsert
      send_op(CMD_DELETE, 12'hAAA, 12'h555);

      // pause once with the block fully drained
      drain_heads();

      // Random part: mostly well-formed chains, with a tenth of pure noise
      // (random command, bucket and position, which may break the lists).
      grow = 1'b1;
      for (n = 0; n < RandomOps; n++) begin
         if (n % 40 == 0)
            send_burst = ($urandom_range(3) == 0);
         if (n == RandomOps / 2)
            drain_heads();
         // swing the live population up and down so chains fill and empty
         if (live_q.size() > 60)
            grow = 1'b0;
         else if (live_q.size() < 4)
            grow = 1'b1;
         if ($urandom_range(9) == 0)
            send_op(cmd_type'($urandom_range(1)), FieldW'($urandom_range(TableSize - 1)),
                    FieldW'($urandom_range(TableSize - 1)));
         else
            send_chain_op($urandom_range(99) < (grow ? 70 : 30));
      end

      // let every head come back, then watch a little longer for strays
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: stall a random number of cycles per response, then
   // take it and check it.
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 50 == 0)
            rsp_burst = ($urandom_range(3) == 0);
         stall = rsp_burst ? 0 : $urandom_range(8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_head(rsp_tdata);
         taken++;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when no item moves on either side for too long
   // -------------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

endmodule
